/* rtl/confirmed_command_frame_receiver_defines.svh */
// assertion macros for the confirmed command frame receiver
`ifndef CONFIRMED_COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define CONFIRMED_COMMAND_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define CCFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define CCFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CCFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/ccfr_pkg.sv */
// shared types and constants of the confirmed command frame receiver
package ccfr_pkg;

    // frame grammar bytes
    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] CMD_BYTE        = 8'h5A;
    localparam logic [7:0] END_BYTE        = 8'h55;
    localparam logic [7:0] CONFIRM_TRAILER = 8'hCC;
    localparam logic [7:0] RELEASE_MARKER  = 8'hAE;
    localparam logic [7:0] MIN_LEN         = 8'd6;

    // widths that cover the largest supported frame buffer (64 bytes a bank)
    localparam int JOB_CNT_W  = 7;
    localparam int MEM_AW_MAX = 7;

    // kind of an emitted byte
    typedef enum logic [1:0] {
        KIND_EXEC    = 2'd0,
        KIND_CONFIRM = 2'd1,
        KIND_BROKEN  = 2'd2
    } t_kind;

    // emitter states
    typedef enum logic {
        EMIT_IDLE,
        EMIT_RUN
    } t_emit_state;

    // one emission job from the parser to the emitter
    typedef struct packed {
        t_kind                  kind;
        logic                   bank;
        logic [JOB_CNT_W-1:0]   count;     // bytes read from the bank
        logic                   has_tail;  // one extra byte after the bank bytes
        logic [7:0]             tail;
        logic                   stray;
    } t_job;

    // frame buffer write port
    typedef struct packed {
        logic                   en;
        logic [MEM_AW_MAX-1:0]  addr;
        logic [7:0]             data;
    } t_mem_wr;

endpackage

/* rtl/confirmed_command_frame_receiver.sv */
// top level of the confirmed command frame receiver
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata data_byte, byte_index,
//                                               stray_start; tuser kind; tlast
//
// one received byte is taken per cycle while the bank being filled is free;
// a byte that breaks a frame, or ends one after an end or confirm trailer,
// queues a readout of 1 to MAX_FRAME_BYTES-1 bytes, sent one per cycle while
// the output does not stall, set by the single read port of the frame buffer;
// an idle emitter pops the job, and back-to-back readouts pass its idle state.
// input stalls while the fill bank is still queued or being read, or the
// two-entry job queue is full; output stalls hold the emitter and reach the
// input only through a busy fill bank or a full queue.
// synchronous active-low reset clears parser, queue and emitter control.
`include "confirmed_command_frame_receiver_defines.svh"

module confirmed_command_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] byte_index,
                                        // [12] stray_start, [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import ccfr_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES);

    t_job       w_job_in, w_job_out;
    t_mem_wr    w_wr;
    t_kind      w_kind;
    logic       w_push, w_pop;
    logic       w_fifo_full, w_fifo_empty;
    logic [1:0] w_busy_fifo, w_busy_back, w_bank_busy;
    logic [7:0] w_data;
    logic [3:0] w_index;
    logic       w_stray;

    assign w_bank_busy = w_busy_fifo | w_busy_back;

    // parser
    ccfr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_bank_busy (w_bank_busy),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .o_wr        (w_wr)
    );

    // job queue
    ccfr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_job_in),
        .i_pop       (w_pop),
        .o_job       (w_job_out),
        .o_empty     (w_fifo_empty),
        .o_full      (w_fifo_full),
        .o_bank_busy (w_busy_fifo)
    );

    // emitter
    ccfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_job       (w_job_out),
        .i_empty     (w_fifo_empty),
        .o_pop       (w_pop),
        .o_bank_busy (w_busy_back),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (w_kind),
        .o_data      (w_data),
        .o_index     (w_index),
        .o_stray     (w_stray),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_stray, w_index, w_data};
    assign m_axis_tuser = w_kind;

    // checks
    `CCFR_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_fifo_full,
        "job pushed into full queue")
    `CCFR_ASSERT_NEVER(a_wr_busy, i_clk, i_rst_n, w_wr.en && w_bank_busy[w_wr.addr[PW]],
        "write into bank awaiting readout")
    `CCFR_ASSERT(a_stray_kind, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tuser == KIND_BROKEN,
        "stray flag on non-broken byte")
    `CCFR_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_pop |-> !w_fifo_empty,
        "job popped from empty queue")

endmodule

/* rtl/ccfr_front.sv */
// byte parser: frame grammar, bank fill and job classification
module ccfr_front #(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic [1:0]        i_bank_busy,
    input  logic              i_fifo_full,
    output logic              o_push,
    output ccfr_pkg::t_job    o_job,
    output ccfr_pkg::t_mem_wr o_wr
);
    import ccfr_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_len, n_len;
    logic          r_bank, n_bank;
    logic [PW-1:0] r_pend_len, n_pend_len;
    logic          r_pend_valid, n_pend_valid;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_marker, n_marker;

    logic          accept;
    logic          go_broken;
    logic [PW:0]   pos_inc;
    logic [PW:0]   len_ext;

    // hold off while the fill bank is still to be read out or the queue is full
    assign o_ready = !i_bank_busy[r_bank] && !i_fifo_full;
    assign accept  = i_valid && o_ready;
    assign pos_inc = {1'b0, r_pos} + (PW+1)'(1);
    assign len_ext = {1'b0, r_len};

    // grammar step for one accepted byte
    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_bank       = r_bank;
        n_pend_len   = r_pend_len;
        n_pend_valid = r_pend_valid;
        n_prev       = r_prev;
        n_marker     = r_marker;
        go_broken    = 1'b0;
        o_push       = 1'b0;
        o_job        = '0;
        o_wr.en      = 1'b0;
        o_wr.addr    = MEM_AW_MAX'({r_bank, r_pos});
        o_wr.data    = i_byte;
        if (accept) begin
            if (r_pos > PW'(2) && r_pos >= r_len) begin
                go_broken = 1'b1;
            end else if (r_pos == PW'(0) && i_byte == SYNC_BYTE) begin
                o_wr.en = 1'b1;
                n_pos   = PW'(1);
            end else if (r_pos == PW'(1) && i_byte == CMD_BYTE) begin
                o_wr.en = 1'b1;
                n_pos   = PW'(2);
            end else if (r_pos == PW'(2) && i_byte >= MIN_LEN
                         && i_byte < 8'(MAX_FRAME_BYTES)) begin
                o_wr.en = 1'b1;
                n_len   = i_byte[PW-1:0];
                n_pos   = PW'(3);
            end else if (r_pos > PW'(2) && pos_inc < len_ext) begin
                o_wr.en = 1'b1;
                n_pos   = pos_inc[PW-1:0];
                n_prev  = i_byte;
                if (r_pos == PW'(3)) begin
                    n_marker = i_byte;
                end
            end else if (r_pos > PW'(2) && pos_inc == len_ext && i_byte == END_BYTE) begin
                o_wr.en = 1'b1;
                n_pos   = '0;
                if (r_prev == END_BYTE) begin
                    o_push      = 1'b1;
                    o_job.kind  = KIND_EXEC;
                    if (r_marker == RELEASE_MARKER && r_pend_valid) begin
                        // release the stored frame instead of this one
                        n_pend_valid = 1'b0;
                        o_job.bank   = !r_bank;
                        o_job.count  = JOB_CNT_W'(r_pend_len);
                    end else begin
                        o_job.bank  = r_bank;
                        o_job.count = JOB_CNT_W'(r_len);
                    end
                end else if (r_prev == CONFIRM_TRAILER) begin
                    // keep this bank, fill the other one from now on
                    o_push       = 1'b1;
                    o_job.kind   = KIND_CONFIRM;
                    o_job.bank   = r_bank;
                    o_job.count  = JOB_CNT_W'(r_len);
                    n_bank       = !r_bank;
                    n_pend_len   = r_len;
                    n_pend_valid = 1'b1;
                end
            end else begin
                go_broken = 1'b1;
            end
        end
        // broken frame: echo the partial frame plus the offending byte
        if (go_broken) begin
            n_pend_valid   = 1'b0;
            n_pos          = '0;
            o_push         = 1'b1;
            o_job.kind     = KIND_BROKEN;
            o_job.bank     = r_bank;
            o_job.count    = JOB_CNT_W'(r_pos);
            o_job.has_tail = 1'b1;
            o_job.tail     = i_byte;
            o_job.stray    = (r_pos == PW'(0));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_len        <= '0;
            r_bank       <= 1'b0;
            r_pend_len   <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_bank       <= n_bank;
            r_pend_len   <= n_pend_len;
            r_pend_valid <= n_pend_valid;
        end
    end

    // trailer and marker copies of the fill bank
    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_marker <= n_marker;
    end

endmodule

/* rtl/ccfr_fifo.sv */
// two-entry job queue between parser and emitter
module ccfr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccfr_pkg::t_job i_job,
    input  logic           i_pop,
    output ccfr_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full,
    output logic [1:0]     o_bank_busy
);
    import ccfr_pkg::*;

    t_job       r_entry [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;
    logic [1:0] entry_valid;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_entry[r_rp];

    // banks that queued jobs still have to read
    always_comb begin
        entry_valid[0] = o_full || (r_cnt == 2'd1 && r_rp == 1'b0);
        entry_valid[1] = o_full || (r_cnt == 2'd1 && r_rp == 1'b1);
        o_bank_busy    = 2'b00;
        for (int e = 0; e < 2; e++) begin
            if (entry_valid[e] && r_entry[e].count != '0) begin
                o_bank_busy[r_entry[e].bank] = 1'b1;
            end
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_job;
        end
    end

endmodule

/* rtl/ccfr_back.sv */
// emitter: frame buffer, readout sequencer and output register
module ccfr_back #(
    parameter int MAX_FRAME_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccfr_pkg::t_mem_wr i_wr,
    input  ccfr_pkg::t_job    i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic [1:0]        o_bank_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output ccfr_pkg::t_kind   o_kind,
    output logic [7:0]        o_data,
    output logic [3:0]        o_index,
    output logic              o_stray,
    output logic              o_last
);
    import ccfr_pkg::*;

    localparam int PW    = $clog2(MAX_FRAME_BYTES);
    localparam int AW    = PW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [7:0]           r_mem [DEPTH];
    logic [7:0]           r_rd_data;

    t_emit_state          r_state, n_state;
    t_job                 r_job;
    logic [JOB_CNT_W-1:0] r_idx;
    logic [JOB_CNT_W-1:0] total;
    logic                 use_mem;
    logic                 idx_last;
    logic                 issue;
    logic                 s2_ready;
    logic                 s1_free;

    logic                 r_s1_valid;
    t_kind                r_s1_kind;
    logic [3:0]           r_s1_index;
    logic                 r_s1_stray;
    logic                 r_s1_last;
    logic                 r_s1_tail_sel;
    logic [7:0]           r_s1_tail;

    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [7:0]           r_out_data;
    logic [3:0]           r_out_index;
    logic                 r_out_stray;
    logic                 r_out_last;

    assign total    = r_job.count + JOB_CNT_W'(r_job.has_tail);
    assign idx_last = (r_idx == total - JOB_CNT_W'(1));
    assign use_mem  = (r_idx < r_job.count);
    assign s2_ready = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || s2_ready;

    // bank held until its last byte has been read
    always_comb begin
        o_bank_busy = 2'b00;
        if (r_state == EMIT_RUN && use_mem) begin
            o_bank_busy[r_job.bank] = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            EMIT_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = EMIT_RUN;
                end
            end
            EMIT_RUN: begin
                if (s1_free) begin
                    issue = 1'b1;
                    if (idx_last) begin
                        n_state = EMIT_IDLE;
                    end
                end
            end
            default: n_state = EMIT_IDLE;
        endcase
    end

    // sequencer state and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EMIT_IDLE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s2_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // job and byte counter
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + JOB_CNT_W'(1);
        end
    end

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (issue && use_mem) begin
            r_rd_data <= r_mem[{r_job.bank, r_idx[PW-1:0]}];
        end
    end

    // read stage side data
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_kind     <= r_job.kind;
            r_s1_index    <= r_idx[3:0];
            r_s1_stray    <= r_job.stray;
            r_s1_last     <= idx_last;
            r_s1_tail_sel <= !use_mem;
            r_s1_tail     <= r_job.tail;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_kind  <= r_s1_kind;
            r_out_data  <= r_s1_tail_sel ? r_s1_tail : r_rd_data;
            r_out_index <= r_s1_index;
            r_out_stray <= r_s1_stray;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_data  = r_out_data;
    assign o_index = r_out_index;
    assign o_stray = r_out_stray;
    assign o_last  = r_out_last;

endmodule

/* bench/tb.sv */
// testbench for the confirmed command frame receiver: byte stream in, predicted output out
`timescale 1ns / 100ps

module tb;
    import ccfr_pkg::*;

    localparam int FRAME_BYTES = 16;
    localparam int PAUSE_MARK = -1;    // plan entry that holds input until output drains
    localparam int QUIET_TAIL = 40;    // last bytes sent with no idling
    localparam int SETTLE_CYCLES = 64;

    // one byte leaving the block
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [3:0]  idx;
        logic        stray;
        logic        last;
    } t_emitted;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] data_byte, [11:8] byte_index, [12] stray_start
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;

    // frame assembler mirror
    logic [7:0]  frame_mem [0:2*FRAME_BYTES-1];
    logic        fill_bank = 1'b0;
    int          fill_pos = 0;
    int          frame_len = 0;
    int          pend_len = 0;
    logic        pend_valid = 1'b0;

    t_emitted    expected_emits[$];
    int          rx_plan[$];
    int          planned_items = 0;
    int          sent_items = 0;
    int          fail_count = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    logic        quiet;

    assign quiet = (sent_items + QUIET_TAIL >= planned_items);

    confirmed_command_frame_receiver #(
        .MAX_FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // read out n stored bytes of one bank
    function void emit_bank(t_kind kind, logic bank, int n);
        for (int i = 0; i < n; i++) begin
            expected_emits.push_back('{kind, frame_mem[{bank, 4'(i)}], 4'(i), 1'b0,
                                       (i == n - 1)});
        end
    endfunction

    // partial frame plus the offending byte, or a lone stray byte
    function void echo_broken(logic [7:0] rx);
        int n;
        n = fill_pos;
        pend_valid = 1'b0;
        fill_pos = 0;
        if (n == 0) begin
            expected_emits.push_back('{KIND_BROKEN, rx, 4'd0, 1'b1, 1'b1});
        end else begin
            for (int i = 0; i < n; i++) begin
                expected_emits.push_back('{KIND_BROKEN, frame_mem[{fill_bank, 4'(i)}],
                                           4'(i), 1'b0, 1'b0});
            end
            expected_emits.push_back('{KIND_BROKEN, rx, 4'(n), 1'b0, 1'b1});
        end
    endfunction

    // frame grammar step for one received byte
    function void receive_byte(logic [7:0] rx);
        int          pos;
        logic        fb;
        logic [7:0]  trailer;
        pos = fill_pos;
        fb = fill_bank;
        if (pos == 0 && rx == SYNC_BYTE) begin
            frame_mem[{fb, 4'd0}] = rx;
            fill_pos = 1;
        end else if (pos == 1 && rx == CMD_BYTE) begin
            frame_mem[{fb, 4'd1}] = rx;
            fill_pos = 2;
        end else if (pos == 2 && rx >= MIN_LEN && rx < FRAME_BYTES) begin
            frame_mem[{fb, 4'd2}] = rx;
            frame_len = rx;
            fill_pos = 3;
        end else if (pos > 2 && pos + 1 < frame_len) begin
            frame_mem[{fb, 4'(pos)}] = rx;
            fill_pos = pos + 1;
        end else if (pos > 2 && pos + 1 == frame_len && rx == END_BYTE) begin
            trailer = frame_mem[{fb, 4'(pos - 1)}];
            frame_mem[{fb, 4'(pos)}] = rx;
            fill_pos = 0;
            if (trailer == END_BYTE) begin
                // a release marker swaps in the stored frame
                if (frame_mem[{fb, 4'd3}] == RELEASE_MARKER && pend_valid) begin
                    pend_valid = 1'b0;
                    emit_bank(KIND_EXEC, !fb, pend_len);
                end else begin
                    emit_bank(KIND_EXEC, fb, frame_len);
                end
            end else if (trailer == CONFIRM_TRAILER) begin
                fill_bank = !fb;
                pend_len = frame_len;
                pend_valid = 1'b1;
                emit_bank(KIND_CONFIRM, fb, frame_len);
            end
            // any other trailer drops the frame silently
        end else begin
            echo_broken(rx);
        end
    endfunction

    // whole frame with random payload and a chosen closing byte
    function void plan_frame(int len, logic [7:0] marker, logic [7:0] trailer,
                             logic [7:0] closer);
        rx_plan.push_back(SYNC_BYTE);
        rx_plan.push_back(CMD_BYTE);
        rx_plan.push_back(len);
        rx_plan.push_back(marker);
        for (int i = 0; i < len - 6; i++) rx_plan.push_back($urandom_range(255));
        rx_plan.push_back(trailer);
        rx_plan.push_back(closer);
    endfunction

    // sender: one byte per transfer, random gaps, pauses until output drains
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                receive_byte(s_axis_tdata);
                sent_items++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_plan.size() > 0 && rx_plan[0] == PAUSE_MARK) begin
                s_axis_tvalid <= 1'b0;
                if (expected_emits.size() == 0) void'(rx_plan.pop_front());
            end else if (rx_plan.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= 8'(rx_plan.pop_front());
                if (!quiet && $urandom_range(5) == 0) send_gap = $urandom_range(1, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(5) == 0) take_gap = $urandom_range(1, 5);
        end
    end

    // output check against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_emitted want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_emits.size() == 0) begin
                $error("unexpected output transfer, data_byte %0h", m_axis_tdata[7:0]);
                fail_count++;
            end else begin
                want = expected_emits.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== want.data) begin
                    $error("data_byte: expected %0h, actual %0h", want.data,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[11:8] !== want.idx) begin
                    $error("byte_index: expected %0d, actual %0d", want.idx,
                           m_axis_tdata[11:8]);
                    fail_count++;
                end
                if (m_axis_tdata[12] !== want.stray) begin
                    $error("stray_start: expected %0d, actual %0d", want.stray,
                           m_axis_tdata[12]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // stimulus plan, reset and end of run
    initial begin
        int          sel;
        int          len;
        logic [7:0]  marker;
        logic [7:0]  odd_byte;
        // stray byte, length too short and too long
        rx_plan.push_back(8'h00);
        rx_plan.push_back(SYNC_BYTE);
        rx_plan.push_back(CMD_BYTE);
        rx_plan.push_back(8'd5);
        rx_plan.push_back(SYNC_BYTE);
        rx_plan.push_back(CMD_BYTE);
        rx_plan.push_back(8'd16);
        // confirmation frame carrying a release marker, its release, release with none pending
        plan_frame(6, RELEASE_MARKER, CONFIRM_TRAILER, END_BYTE);
        plan_frame(6, RELEASE_MARKER, END_BYTE, END_BYTE);
        plan_frame(6, RELEASE_MARKER, END_BYTE, END_BYTE);
        rx_plan.push_back(PAUSE_MARK);

        // random part: mostly well-formed frames, some broken ones and noise
        while (planned_items < 370) begin
            sel = $urandom_range(99);
            len = $urandom_range(6, 15);
            marker = ($urandom_range(3) == 0) ? RELEASE_MARKER : 8'($urandom_range(255));
            if (sel < 40) begin
                plan_frame(len, marker, END_BYTE, END_BYTE);
            end else if (sel < 60) begin
                plan_frame(len, marker, CONFIRM_TRAILER, END_BYTE);
            end else if (sel < 68) begin
                do odd_byte = 8'($urandom_range(255));
                while (odd_byte == END_BYTE || odd_byte == CONFIRM_TRAILER);
                plan_frame(len, marker, odd_byte, END_BYTE);
            end else if (sel < 76) begin
                do odd_byte = 8'($urandom_range(255)); while (odd_byte == END_BYTE);
                plan_frame(len, marker,
                           ($urandom_range(1) == 0) ? END_BYTE : CONFIRM_TRAILER, odd_byte);
            end else if (sel < 82) begin
                do odd_byte = 8'($urandom_range(255)); while (odd_byte == CMD_BYTE);
                rx_plan.push_back(SYNC_BYTE);
                rx_plan.push_back(odd_byte);
            end else if (sel < 88) begin
                rx_plan.push_back(SYNC_BYTE);
                rx_plan.push_back(CMD_BYTE);
                rx_plan.push_back(($urandom_range(1) == 0) ? $urandom_range(5)
                                                           : $urandom_range(16, 255));
            end else if (sel < 97) begin
                repeat ($urandom_range(1, 3)) rx_plan.push_back($urandom_range(255));
            end else begin
                rx_plan.push_back(PAUSE_MARK);
            end
            planned_items = 0;
            foreach (rx_plan[i]) if (rx_plan[i] != PAUSE_MARK) planned_items++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_items < planned_items) @(posedge i_clk);
        while (expected_emits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_emits.size() != 0) begin
            $error("%0d expected output transfers never arrived", expected_emits.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("confirmed_command_frame_receiver verification clean");
        end else begin
            $display("confirmed_command_frame_receiver verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #500000;
        $display("confirmed_command_frame_receiver verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ccfr_pkg.sv
rtl/ccfr_front.sv
rtl/ccfr_fifo.sv
rtl/ccfr_back.sv
rtl/confirmed_command_frame_receiver.sv
bench/tb.sv
